// ===== hdl/ptps_pkg.sv =====
// ----------------------------------------------------------------------------
// Plate thermal profile stress: shared package
// Default sizes, field widths, register indexes and the output clamp.
// ----------------------------------------------------------------------------
package ptps_pkg;

    localparam int MAX_CELLS_DEF = 64;
    localparam int TEMP_BITS_DEF = 24;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_EXPANSION_COEFF = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAXIAL_MODULUS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_TEMP  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THICKNESS       = 8'd3;

    localparam int REF_W     = 24;
    localparam int THICK_W   = 24;
    localparam int COEF_W    = 32;
    localparam int RES_W     = 32;
    localparam int WK_W      = 64;
    localparam int DIVISOR_W = 32;
    localparam int PROD_W    = WK_W + COEF_W;
    localparam int OUT_TDATA_W = 3 * RES_W;

    // Micrometres to metres together with the 2^-35 alignment of the moment.
    localparam logic [COEF_W-1:0] CURV_SCALE = 32'd15625;

    // Clamp a sign and magnitude pair to the signed 32-bit range.
    function automatic logic [RES_W-1:0] sat32(input logic neg, input logic [WK_W-1:0] m);
        logic [RES_W-1:0] r;
        if (neg)
        begin
            if (m >= 64'h0000_0000_8000_0000)
                r = 32'h8000_0000;
            else
                r = 32'(-m[RES_W-1:0]);
        end
        else
        begin
            if (m > 64'h0000_0000_7FFF_FFFF)
                r = 32'h7FFF_FFFF;
            else
                r = m[RES_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== hdl/ptps_store.sv =====
// ----------------------------------------------------------------------------
// Plate thermal profile stress: sample memory
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ptps_store #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 24
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/ptps_div.sv =====
// ----------------------------------------------------------------------------
// Plate thermal profile stress: unsigned divider
// Restoring divider, one quotient bit per cycle, quotient rounds toward zero.
// ----------------------------------------------------------------------------
module ptps_div #(
    parameter int DW = 64,
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CNTW = $clog2(DW + 1);

    logic [DW-1:0]   quo_reg;
    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   div_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [VW:0]     trial;
    logic [VW:0]     diff;
    logic            fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = trial >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNTW'(DW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNTW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], fits};
            rem_reg <= fits ? diff[VW-1:0] : trial[VW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/ptps_mul.sv =====
// ----------------------------------------------------------------------------
// Plate thermal profile stress: wide multiplier
// 64 x 32 bit product formed from two 32 x 32 partial products on one array.
// ----------------------------------------------------------------------------
module ptps_mul (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ptps_pkg::WK_W-1:0]    a,
    input  logic [ptps_pkg::COEF_W-1:0]  b,
    output logic                         done,
    output logic [ptps_pkg::PROD_W-1:0]  prod
);

    import ptps_pkg::*;

    logic [31:0]       a_hi_reg;
    logic [COEF_W-1:0] b_reg;
    logic [63:0]       lo_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              phase_reg;
    logic              done_reg;
    logic [31:0]       op_a;
    logic [COEF_W-1:0] op_b;
    logic [63:0]       pp;

    // The low half is multiplied in the start cycle, the high half next.
    assign op_a = start ? a[31:0] : a_hi_reg;
    assign op_b = start ? b : b_reg;
    assign pp   = 64'(op_a) * 64'(op_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= start;
            done_reg  <= phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_hi_reg <= a[63:32];
            b_reg    <= b;
            lo_reg   <= pp;
        end
        if (phase_reg)
        begin
            prod_reg <= {pp, 32'b0} + PROD_W'(lo_reg);
        end
    end

    assign done = done_reg;
    assign prod = prod_reg;

endmodule

// ===== hdl/plate_thermal_profile_stress_unit.sv =====
// ----------------------------------------------------------------------------
// Plate thermal profile stress unit
// Loads a through-thickness temperature profile and emits per-cell stresses, membrane strain and curvature.
// ----------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_t* channel, wall to wall, one transfer per cycle
//   while s_tready is high; s_tlast marks the final sample. Up to MAX_CELLS
//   samples are stored; more are dropped and reported through m_tuser on
//   every result of the profile. After the last sample the unit reads the
//   profile back from its memory and combines the Simpson sums in S_PREP1
//   and S_PREP2. It then runs four divisions and three multiplications; with
//   fewer than two samples or a zero thickness it skips these and strain and
//   curvature are zero. It then emits one result per stored sample on m_t*,
//   each set by one memory read and two passes through the shared multiplier.
//   s_tready is low from the last sample until the last result is loaded
//   into the output register. A stalled receiver holds the output register
//   and the sequencer waits; nothing is lost.
//   Configuration writes are taken every cycle on cfg_*; write them only
//   while no profile is being processed. Reset clears the registers, the
//   sample count and the overflow flag; the memory needs no clearing pass.
// ----------------------------------------------------------------------------
module plate_thermal_profile_stress_unit #(
    parameter int MAX_CELLS = ptps_pkg::MAX_CELLS_DEF,
    parameter int TEMP_BITS = ptps_pkg::TEMP_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: temperature[TEMP_BITS-1:0], zero padding above
    input  logic [((TEMP_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic                                s_tlast,
    // tdata: residual_stress[31:0], membrane_strain[63:32], curvature[95:64]
    output logic [ptps_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic                                m_tlast,
    // tuser: overflow[0]
    output logic                                m_tuser,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ptps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptps_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import ptps_pkg::*;

    localparam int TB  = TEMP_BITS;
    localparam int CW  = $clog2(MAX_CELLS + 1);
    localparam int AW  = $clog2(MAX_CELLS);
    localparam int SW  = TB + CW + 1;
    localparam int WW  = TB + 2 * CW + 2;
    localparam int DTW = ((TB > REF_W) ? TB : REF_W) + 1;
    localparam int EW  = TB + 2;
    localparam int NW  = CW + 4;

    typedef enum logic [15:0] {
        S_LOAD  = 16'h0001,
        S_SUM   = 16'h0002,
        S_PREP1 = 16'h0004,
        S_PREP2 = 16'h0008,
        S_DSTR  = 16'h0010,
        S_MSTR  = 16'h0020,
        S_DQ1   = 16'h0040,
        S_DQ2   = 16'h0080,
        S_MW    = 16'h0100,
        S_MX    = 16'h0200,
        S_DCURV = 16'h0400,
        S_RD    = 16'h0800,
        S_RWAIT = 16'h1000,
        S_MTH   = 16'h2000,
        S_MSIG  = 16'h4000,
        S_EMIT  = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic [COEF_W-1:0]       alpha_reg;
    logic [COEF_W-1:0]       modulus_reg;
    logic signed [REF_W-1:0] tref_reg;
    logic [THICK_W-1:0]      thick_reg;

    // Load side
    logic [CW-1:0] cnt_reg;
    logic          ovf_reg;
    logic          accept;
    logic          full;
    logic [CW-1:0] cnt_after;

    // Profile processing
    logic [CW-1:0]          n_reg, issue_reg, ridx_reg, idx_reg;
    logic                   ovf_prof_reg;
    logic                   rv_reg;
    logic                   launched_reg;
    logic signed [SW-1:0]   sum_t_reg;
    logic signed [WW-1:0]   sum_w_reg;
    logic signed [TB-1:0]   t0_reg, t1_reg, tn1_reg, tn2_reg;
    logic signed [63:0]     s2_reg, nsum_reg, ne_reg, ntref_reg;
    logic [WK_W-1:0]        d_mag_reg, f_mag_reg, wk_reg;
    logic                   d_neg_reg, f_neg_reg;
    logic [RES_W-1:0]       strain_reg, curv_reg, sig_reg;
    logic [DTW-1:0]         dt_mag_reg;
    logic                   dt_neg_reg;
    logic [WK_W-1:0]        dif_mag_reg;
    logic                   dif_neg_reg;

    // Output register
    logic             out_valid_reg;
    logic [RES_W-1:0] out_sig_reg, out_strain_reg, out_curv_reg;
    logic             out_last_reg, out_ovf_reg;
    logic             slot_free;

    // Memory port
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    logic [TB-1:0] mem_rdata;

    // Arithmetic units
    logic              div_start, div_done, mul_start, mul_done;
    logic              is_div, is_mul;
    logic [WK_W-1:0]   div_a, div_q, mul_a;
    logic [DIVISOR_W-1:0] div_b;
    logic [COEF_W-1:0] mul_b;
    logic [PROD_W-1:0] mul_p;

    // Datapath helpers
    logic [CW-1:0]             n_last, n_pen;
    logic [CW:0]               odd;
    logic signed [TB+CW+1:0]   w_term;
    logic signed [EW-1:0]      e_val;
    logic signed [EW-1:0]      fe_val;
    logic signed [CW+SW:0]     nsum_prod;
    logic signed [CW+EW:0]     ne_prod;
    logic [NW-1:0]             twelve_n;
    logic signed [NW+REF_W:0]  ntref_prod;
    logic signed [63:0]        d_val, f_val;
    logic signed [DTW-1:0]     dt_val;
    logic signed [63:0]        th_val, sdiff;

    assign s_tready  = (state_reg == S_LOAD);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign full      = (cnt_reg == CW'(MAX_CELLS));
    assign cnt_after = full ? cnt_reg : cnt_reg + 1'b1;
    assign slot_free = !out_valid_reg || m_tready;

    assign n_last = n_reg - 1'b1;
    assign n_pen  = n_reg - CW'(2);

    assign mem_we    = accept && !full;
    assign mem_re    = ((state_reg == S_SUM) && (issue_reg < n_reg)) || (state_reg == S_RD);
    assign mem_raddr = (state_reg == S_RD) ? idx_reg[AW-1:0] : issue_reg[AW-1:0];

    ptps_store #(
        .DEPTH (MAX_CELLS),
        .WIDTH (TB)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (s_tdata[TB-1:0]),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign is_div = (state_reg == S_DSTR) || (state_reg == S_DQ1) ||
                    (state_reg == S_DQ2) || (state_reg == S_DCURV);
    assign is_mul = (state_reg == S_MSTR) || (state_reg == S_MW) || (state_reg == S_MX) ||
                    (state_reg == S_MTH) || (state_reg == S_MSIG);
    assign div_start = is_div && !launched_reg;
    assign mul_start = is_mul && !launched_reg;

    always_comb
    begin
        div_a = '0;
        div_b = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_DSTR:
            begin
                div_a = d_mag_reg << 8;
                div_b = DIVISOR_W'(twelve_n);
            end
            S_DQ1:
            begin
                div_a = f_mag_reg << 7;
                div_b = DIVISOR_W'(n_reg);
            end
            S_DQ2:
            begin
                div_a = wk_reg << 9;
                div_b = DIVISOR_W'(n_reg);
            end
            S_DCURV:
            begin
                div_a = wk_reg;
                div_b = DIVISOR_W'(thick_reg);
            end
            S_MSTR, S_MW:
            begin
                mul_a = wk_reg;
                mul_b = alpha_reg;
            end
            S_MX:
            begin
                mul_a = wk_reg;
                mul_b = CURV_SCALE;
            end
            S_MTH:
            begin
                mul_a = WK_W'(dt_mag_reg);
                mul_b = alpha_reg;
            end
            S_MSIG:
            begin
                mul_a = dif_mag_reg;
                mul_b = modulus_reg;
            end
            default:
            begin
                div_a = '0;
            end
        endcase
    end

    ptps_div #(
        .DW (WK_W),
        .VW (DIVISOR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    ptps_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_p)
    );

    // Closed form of the per-cell Simpson sums: with E = T0 - T1 + Tn-1 - Tn-2
    // and G = T0 - T1 - Tn-1 + Tn-2,
    // S2 = 12*sum(T) + E and F = 12*(sum((2i+1)T) - n*sum(T)) - n*G.
    assign odd        = {ridx_reg, 1'b1};
    assign w_term     = $signed({1'b0, odd}) * $signed(mem_rdata);
    assign e_val      = EW'(t0_reg) - EW'(t1_reg) + EW'(tn1_reg) - EW'(tn2_reg);
    assign fe_val     = EW'(t0_reg) - EW'(t1_reg) - EW'(tn1_reg) + EW'(tn2_reg);
    assign nsum_prod  = $signed({1'b0, n_reg}) * sum_t_reg;
    assign ne_prod    = $signed({1'b0, n_reg}) * fe_val;
    assign twelve_n   = NW'(n_reg) * NW'(12);
    assign ntref_prod = $signed({1'b0, twelve_n}) * tref_reg;
    assign d_val      = s2_reg - ntref_reg;
    assign f_val      = (64'(sum_w_reg) - nsum_reg) * 64'sd12 - ne_reg;
    assign dt_val     = DTW'($signed(mem_rdata)) - DTW'(tref_reg);
    assign th_val     = $signed(64'(mul_p[79:16]));
    assign sdiff      = (dt_neg_reg ? -th_val : th_val) - 64'($signed(strain_reg));

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (accept && s_tlast)
                begin
                    if ((cnt_after >= CW'(2)) && (thick_reg != '0))
                        state_next = S_SUM;
                    else
                        state_next = S_RD;
                end
            end
            S_SUM:
            begin
                if (rv_reg && (ridx_reg == n_last))
                    state_next = S_PREP1;
            end
            S_PREP1: state_next = S_PREP2;
            S_PREP2: state_next = S_DSTR;
            S_DSTR:  if (div_done) state_next = S_MSTR;
            S_MSTR:  if (mul_done) state_next = S_DQ1;
            S_DQ1:   if (div_done) state_next = S_DQ2;
            S_DQ2:   if (div_done) state_next = S_MW;
            S_MW:    if (mul_done) state_next = S_MX;
            S_MX:    if (mul_done) state_next = S_DCURV;
            S_DCURV: if (div_done) state_next = S_RD;
            S_RD:    state_next = S_RWAIT;
            S_RWAIT: state_next = S_MTH;
            S_MTH:   if (mul_done) state_next = S_MSIG;
            S_MSIG:  if (mul_done) state_next = S_EMIT;
            S_EMIT:
            begin
                if (slot_free)
                    state_next = (idx_reg == n_last) ? S_LOAD : S_RD;
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            alpha_reg     <= '0;
            modulus_reg   <= '0;
            tref_reg      <= '0;
            thick_reg     <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            rv_reg        <= 1'b0;
            launched_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_EXPANSION_COEFF)
                    alpha_reg <= cfg_data;
                else if (cfg_index == REG_BIAXIAL_MODULUS)
                    modulus_reg <= cfg_data;
                else if (cfg_index == REG_REFERENCE_TEMP)
                    tref_reg <= $signed(cfg_data[REF_W-1:0]);
                else if (cfg_index == REG_THICKNESS)
                    thick_reg <= cfg_data[THICK_W-1:0];
            end

            if (accept)
            begin
                if (s_tlast)
                begin
                    cnt_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    cnt_reg <= cnt_after;
                    ovf_reg <= ovf_reg | full;
                end
            end

            rv_reg <= (state_reg == S_SUM) && mem_re;

            if (div_start || mul_start)
                launched_reg <= 1'b1;
            else if (div_done || mul_done)
                launched_reg <= 1'b0;

            if ((state_reg == S_EMIT) && slot_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ridx_reg <= issue_reg;

        if (accept && s_tlast)
        begin
            n_reg        <= cnt_after;
            ovf_prof_reg <= ovf_reg | full;
            sum_t_reg    <= '0;
            sum_w_reg    <= '0;
            issue_reg    <= '0;
            idx_reg      <= '0;
            strain_reg   <= '0;
            curv_reg     <= '0;
        end

        if ((state_reg == S_SUM) && mem_re)
            issue_reg <= issue_reg + 1'b1;

        if ((state_reg == S_SUM) && rv_reg)
        begin
            sum_t_reg <= sum_t_reg + SW'($signed(mem_rdata));
            sum_w_reg <= sum_w_reg + WW'(w_term);
            if (ridx_reg == '0)
                t0_reg <= $signed(mem_rdata);
            if (ridx_reg == CW'(1))
                t1_reg <= $signed(mem_rdata);
            if (ridx_reg == n_pen)
                tn2_reg <= $signed(mem_rdata);
            if (ridx_reg == n_last)
                tn1_reg <= $signed(mem_rdata);
        end

        if (state_reg == S_PREP1)
        begin
            s2_reg    <= 64'(sum_t_reg) * 64'sd12 + 64'(e_val);
            nsum_reg  <= 64'(nsum_prod);
            ne_reg    <= 64'(ne_prod);
            ntref_reg <= 64'(ntref_prod);
        end

        if (state_reg == S_PREP2)
        begin
            d_neg_reg <= d_val[63];
            f_neg_reg <= f_val[63];
            d_mag_reg <= d_val[63] ? 64'(-d_val) : 64'(d_val);
            f_mag_reg <= f_val[63] ? 64'(-f_val) : 64'(f_val);
        end

        if (div_done)
        begin
            if (state_reg == S_DCURV)
                curv_reg <= sat32(f_neg_reg, div_q);
            else
                wk_reg <= div_q;
        end

        if (mul_done)
        begin
            if (state_reg == S_MSTR)
                strain_reg <= sat32(d_neg_reg, mul_p[87:24]);
            if (state_reg == S_MW)
                wk_reg <= WK_W'(mul_p[95:35]);
            if (state_reg == S_MX)
                wk_reg <= mul_p[63:0];
            if (state_reg == S_MTH)
            begin
                dif_neg_reg <= sdiff[63];
                dif_mag_reg <= sdiff[63] ? 64'(-sdiff) : 64'(sdiff);
            end
            if (state_reg == S_MSIG)
                sig_reg <= sat32(dif_neg_reg, mul_p[95:32]);
        end

        if (state_reg == S_RWAIT)
        begin
            dt_neg_reg <= dt_val[DTW-1];
            dt_mag_reg <= dt_val[DTW-1] ? DTW'(-dt_val) : DTW'(dt_val);
        end

        if ((state_reg == S_EMIT) && slot_free)
        begin
            out_sig_reg    <= sig_reg;
            out_strain_reg <= strain_reg;
            out_curv_reg   <= curv_reg;
            out_last_reg   <= (idx_reg == n_last);
            out_ovf_reg    <= ovf_prof_reg;
            idx_reg        <= idx_reg + 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_curv_reg, out_strain_reg, out_sig_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

// ===== hdl/ptps_checker.sv =====
// ----------------------------------------------------------------------------
// Plate thermal profile stress: port checker
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module ptps_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic [ptps_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic                             m_tlast
);

    import ptps_pkg::*;

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // Taking the final sample of a profile closes the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last sample");

    // While a result that is not the profile's last waits, no new sample is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input open in the middle of a result run");

endmodule

bind plate_thermal_profile_stress_unit ptps_checker u_ptps_checker (.*);

// ===== dv/tb_plate_thermal_profile_stress_unit.sv =====
// ----------------------------------------------------------------------------
// Plate thermal profile stress unit: self-checking testbench
// Streams temperature profiles through the unit under several register
// settings. An in-bench integer predictor forms the expected per-cell results,
// and each output transfer is compared field by field as it arrives.
// ----------------------------------------------------------------------------
module tb_plate_thermal_profile_stress_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import ptps_pkg::*;

    localparam int CELLS      = MAX_CELLS_DEF;
    localparam int IDLE_LIMIT = 12000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd9;

    typedef struct packed {
        logic [31:0] stress;
        logic [31:0] strain;
        logic [31:0] curv;
        logic        eop;
        logic        ovf;
    } cell_result_t;

    logic                  clk;
    logic                  rst_n;
    logic [23:0]           s_tdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic                  s_tlast;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    plate_thermal_profile_stress_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor state: registers and the profile being loaded.
    logic [31:0] alpha_q;
    logic [31:0] modulus_q;
    longint      tref_q;
    logic [23:0] thick_q;
    longint      profile_q[$];
    bit          dropped_q;

    cell_result_t expected_cells[$];

    int  mismatches;
    int  profiles_sent;
    int  samples_sent;
    int  results_seen;
    int  stall_request;
    bit  calm;
    int  idle_cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [63:0] mag64(longint x);
        return (x < 0) ? 64'(-x) : 64'(x);
    endfunction

    function automatic logic [63:0] scaled_product(logic [63:0] a, logic [31:0] b, int s);
        logic [127:0] p;
        p = {64'b0, a} * {96'b0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic logic [31:0] clamp32(logic neg, logic [63:0] m);
        if (neg)
            return (m >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-m);
        return (m > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    // Twice the temperature at a cell face; the walls are extrapolated.
    function automatic longint twice_face(int i, int n);
        if (i == 0)
            return 3 * profile_q[0] - profile_q[1];
        if (i == n)
            return 3 * profile_q[n-1] - profile_q[n-2];
        return profile_q[i-1] + profile_q[i];
    endfunction

    // Load one sample; on a last mark, queue one expected result per cell.
    task automatic predict_sample(logic [23:0] t, logic last);
        int           n;
        longint       s2;
        longint       fm;
        longint       a;
        longint       b;
        longint       t8;
        longint       k;
        longint       d;
        longint       strain;
        longint       dt;
        longint       dif;
        logic [63:0]  m;
        logic [63:0]  q;
        logic [63:0]  w;
        logic [63:0]  th;
        logic [31:0]  curv;
        cell_result_t r;
        if (profile_q.size() < CELLS)
            profile_q.push_back(longint'(signed'(t)));
        else
            dropped_q = 1'b1;
        if (!last)
            return;
        n      = profile_q.size();
        strain = 0;
        curv   = '0;
        if (n >= 2 && thick_q != 0)
        begin
            s2 = 0;
            fm = 0;
            for (int i = 0; i < n; i++)
            begin
                a  = twice_face(i, n);
                b  = twice_face(i + 1, n);
                t8 = 8 * profile_q[i];
                k  = 2 * i - n;
                s2 += a + t8 + b;
                fm += a * k + t8 * (k + 1) + b * (k + 2);
            end
            d      = s2 - 12 * n * tref_q;
            m      = (mag64(d) << 8) / (12 * n);
            strain = longint'(signed'(clamp32(d < 0, scaled_product(m, alpha_q, 24))));
            q      = (((mag64(fm) << 7) / n) << 9) / n;
            w      = scaled_product(q, alpha_q, 35);
            curv   = clamp32(fm < 0, (w * 64'd15625) / thick_q);
        end
        for (int i = 0; i < n; i++)
        begin
            dt       = profile_q[i] - tref_q;
            th       = (mag64(dt) * alpha_q) >> 16;
            dif      = ((dt < 0) ? -longint'(th) : longint'(th)) - strain;
            r.stress = clamp32(dif < 0, scaled_product(mag64(dif), modulus_q, 32));
            r.strain = strain[31:0];
            r.curv   = curv;
            r.eop    = (i == n - 1);
            r.ovf    = dropped_q;
            expected_cells.push_back(r);
        end
        profile_q.delete();
        dropped_q = 1'b0;
        profiles_sent++;
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_EXPANSION_COEFF: alpha_q   = val;
            REG_BIAXIAL_MODULUS: modulus_q = val;
            REG_REFERENCE_TEMP:  tref_q    = longint'(signed'(val[23:0]));
            REG_THICKNESS:       thick_q   = val[23:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(logic [23:0] t, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= t;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        samples_sent++;
        predict_sample(t, last);
    endtask

    // Let the unit drain, then leave its latency on top before touching registers.
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [23:0] pick_temp(int style, int i, logic [23:0] base);
        case (style)
            0: return 24'($urandom);
            1: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            2: return base + 24'($urandom_range(0, 511)) - 24'd256;
            default: return base + 24'(i * 64);
        endcase
    endfunction

    task automatic send_profile(int len);
        int          style;
        logic [23:0] base;
        style = $urandom_range(0, 4);
        base  = tref_q[23:0] + 24'($urandom_range(0, 20000)) - 24'd10000;
        for (int i = 0; i < len; i++)
            send_sample(pick_temp((style == 4) ? $urandom_range(0, 3) : style, i, base),
                        i == len - 1);
    endtask

    task automatic test_directed();
        calm = 1'b0;
        write_register(REG_EXPANSION_COEFF, 32'd12_000_000);
        write_register(REG_BIAXIAL_MODULUS, 32'd200_000_000);
        write_register(REG_REFERENCE_TEMP, 32'h012C00);
        write_register(REG_THICKNESS, 32'd2000);
        // A write to an index past the register list must change nothing.
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        // Single sample: no integration; then profiles of two, four and three samples.
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h000000, 1'b0);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'hFFFFFF, 1'b1);
        send_sample(24'h012C00, 1'b0);
        send_sample(24'h015000, 1'b0);
        send_sample(24'h019000, 1'b1);
        wait_idle();
        // Zero thickness: stresses only.
        write_register(REG_THICKNESS, 32'd0);
        send_sample(24'h020000, 1'b0);
        send_sample(24'h010000, 1'b0);
        send_sample(24'h7FFFFF, 1'b1);
        wait_idle();
    endtask

    task automatic test_saturation();
        write_register(REG_EXPANSION_COEFF, 32'hFFFF_FFFF);
        write_register(REG_BIAXIAL_MODULUS, 32'hFFFF_FFFF);
        write_register(REG_REFERENCE_TEMP, 32'h0080_0000);
        write_register(REG_THICKNESS, 32'd1);
        send_profile(5);
        send_profile(2);
        wait_idle();
        write_register(REG_REFERENCE_TEMP, 32'h007F_FFFF);
        write_register(REG_THICKNESS, 32'hFF_FFFF);
        send_profile(6);
        wait_idle();
    endtask

    task automatic random_config();
        write_register(REG_EXPANSION_COEFF,
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 40_000_000));
        write_register(REG_BIAXIAL_MODULUS,
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400_000_000));
        write_register(REG_REFERENCE_TEMP,
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 160_000));
        write_register(REG_THICKNESS,
                       $urandom_range(0, 5) == 0 ? 32'($urandom_range(0, 1)) : $urandom);
    endtask

    task automatic test_random_profiles();
        int target;
        target = samples_sent + 250;
        while (samples_sent < target)
        begin
            calm = ($urandom_range(0, 3) == 0);
            random_config();
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 9))
                    0: send_profile(CELLS + $urandom_range(0, 6));
                    1: send_profile($urandom_range(1, 2));
                    default: send_profile($urandom_range(3, 12));
                endcase
            end
            wait_idle();
        end
    endtask

    // Receiver holds off for a long time while profiles keep coming.
    task automatic test_backpressure();
        calm = 1'b1;
        stall_request = 3000;
        send_profile(8);
        send_profile(5);
        send_profile(3);
        wait_idle();
    endtask

    // Result side: random ready gaps, a long hold on request, checks each transfer.
    initial
    begin
        int           gap;
        cell_result_t exp_r;
        cell_result_t got;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall_request) @(negedge clk);
                stall_request = 0;
            end
            else
            begin
                gap = calm ? 0 : $urandom_range(0, 7);
                if (gap > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            results_seen++;
            got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tlast, m_tuser};
            if (expected_cells.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", got);
            end
            else
            begin
                exp_r = expected_cells.pop_front();
                if (got !== exp_r)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: stress exp %h got %h, strain exp %h got %h, ",
                                  "curv exp %h got %h, eop exp %b got %b, ovf exp %b got %b"},
                                 exp_r.stress, got.stress, exp_r.strain, got.strain,
                                 exp_r.curv, got.curv, exp_r.eop, got.eop,
                                 exp_r.ovf, got.ovf);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        s_tdata       = '0;
        s_tvalid      = 1'b0;
        s_tlast       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        alpha_q       = '0;
        modulus_q     = '0;
        tref_q        = 0;
        thick_q       = '0;
        dropped_q     = 1'b0;
        mismatches    = 0;
        profiles_sent = 0;
        samples_sent  = 0;
        results_seen  = 0;
        stall_request = 0;
        calm          = 1'b0;
        idle_cycles   = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_saturation();
        test_backpressure();
        test_random_profiles();
        wait_idle();

        $display("covered %0d profiles, %0d samples, %0d cell results",
                 profiles_sent, samples_sent, results_seen);
        $display("including short, zero-thickness, saturating and overflowing profiles");
        if (mismatches == 0 && expected_cells.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ptps_pkg.sv
hdl/ptps_store.sv
hdl/ptps_div.sv
hdl/ptps_mul.sv
hdl/plate_thermal_profile_stress_unit.sv
hdl/ptps_checker.sv
dv/tb_plate_thermal_profile_stress_unit.sv
